@@ rtl/kfc_pkg.sv @@
// Shared constants and types of the k-mer frequency counter.
`default_nettype none
package kfc_pkg;

	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int BIN_W   = 14;
	localparam int FIELD_W = 24;
	localparam int KLEN_W  = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SEQ   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// response codes
	localparam logic RESP_READ  = 1'b0;
	localparam logic RESP_CLEAR = 1'b1;

	// configuration register indexes
	localparam logic REG_KMER_LENGTH = 1'b0;
	localparam logic REG_MAX_BASES   = 1'b1;

	localparam logic [KLEN_W-1:0]  KMER_LENGTH_RESET = 3'd7;
	localparam logic [FIELD_W-1:0] MAX_BASES_RESET   = 24'd1000000;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_A_UC    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C_UC    = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G_UC    = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T_UC    = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_A_LC    = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_C_LC    = 8'h63;
	localparam logic [CHAR_W-1:0] CHAR_G_LC    = 8'h67;
	localparam logic [CHAR_W-1:0] CHAR_T_LC    = 8'h74;

	// commands from the sequencer to the window tracker
	typedef struct packed {
		logic step;  // sequence byte item taken
		logic clear; // start a new sequence
	} kfc_win_ctl_t;

endpackage
`default_nettype wire

@@ rtl/kfc_hist_mem.sv @@
// Histogram store: one write port, one read port, registered read data.
`default_nettype none
module kfc_hist_mem #(
	parameter int AW = 14,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/kfc_window.sv @@
// Header skip, base decode, rolling window and base counter.
`default_nettype none
module kfc_window #(
	parameter int MAX_KMER = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kfc_pkg::kfc_win_ctl_t         ctl,
	input  wire logic [kfc_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [kfc_pkg::KLEN_W-1:0]    kmer_length,
	input  wire logic [kfc_pkg::FIELD_W-1:0]   max_bases,
	output logic                               count_en,
	output logic      [2*MAX_KMER-1:0]         win_next,
	output logic      [kfc_pkg::FIELD_W-1:0]   bases_seen
);
	import kfc_pkg::*;

	localparam int W = 2 * MAX_KMER;

	logic [W-1:0]       win_q;
	logic [FIELD_W-1:0] base_cnt_q;
	logic               in_header_q;

	logic [KLEN_W-1:0]  k_eff;
	logic [3:0]         shamt;
	logic [W-1:0]       mask;
	logic [1:0]         code;
	logic               code_ok;
	logic               take;
	logic [FIELD_W-1:0] cnt_next;

	always_comb begin
		if (kmer_length == '0) begin
			k_eff = KLEN_W'(1);
		end else if (int'(kmer_length) > MAX_KMER) begin
			k_eff = KLEN_W'(MAX_KMER);
		end else begin
			k_eff = kmer_length;
		end
	end

	always_comb begin
		code_ok = 1'b1;
		case (char_code) inside
			CHAR_A_UC, CHAR_A_LC: code = 2'd0;
			CHAR_C_UC, CHAR_C_LC: code = 2'd1;
			CHAR_G_UC, CHAR_G_LC: code = 2'd2;
			CHAR_T_UC, CHAR_T_LC: code = 2'd3;
			default: begin
				code    = 2'd0;
				code_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < W; i++) begin
			mask[i] = (i < 2 * int'(k_eff));
		end
	end

	assign shamt    = 4'({k_eff, 1'b0}) - 4'd2;
	assign win_next = ((win_q >> 2) | (W'(code) << shamt)) & mask;
	assign cnt_next = base_cnt_q + FIELD_W'(1);
	assign take     = ctl.step && !in_header_q && code_ok && (base_cnt_q < max_bases);
	assign count_en = take && (cnt_next >= FIELD_W'(k_eff));
	assign bases_seen = base_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			base_cnt_q  <= '0;
			in_header_q <= 1'b1;
		end else if (ctl.clear) begin
			win_q       <= '0;
			base_cnt_q  <= '0;
			in_header_q <= 1'b1;
		end else if (ctl.step) begin
			if (in_header_q) begin
				if (char_code == CHAR_NEWLINE) begin
					in_header_q <= 1'b0;
				end
			end else if (take) begin
				win_q      <= win_next;
				base_cnt_q <= cnt_next;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/kmer_frequency_counter.sv @@
// Top level of the k-mer frequency counter: sequencer, config and output register.
// Builds a saturating histogram of k-mers from a FASTA byte stream held in one
// synchronous memory of 4^MAX_KMER counters. A sequence byte that does not
// complete a counted k-mer leaves the sequencer idle; one that counts a bin does
// a read then a write-back of the same histogram entry through the single
// read/write port pair. A bin read waits for the output register to drain. A
// clear request walks the whole table, one entry a cycle, and then replies.
// The same walk runs after reset, during which no item is accepted; configuration
// writes are taken at any time and apply to the next item.
`default_nettype none
module kmer_frequency_counter #(
	parameter int MAX_KMER    = 7,
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [kfc_pkg::FIELD_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [kfc_pkg::REQ_W-1:0]     req_type,
	input  wire logic [kfc_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [kfc_pkg::BIN_W-1:0]     bin_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               resp_kind,
	output logic      [kfc_pkg::FIELD_W-1:0]   bin_count,
	output logic      [kfc_pkg::FIELD_W-1:0]   bases_seen
);
	import kfc_pkg::*;

	localparam int AW = 2 * MAX_KMER;
	localparam int CW = COUNT_WIDTH;

	typedef enum logic [3:0] {
		ST_SWEEP = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_INC   = 4'b0100,
		ST_RESP  = 4'b1000
	} kfc_state_t;

	kfc_state_t state_q;

	logic [KLEN_W-1:0]  kmer_length_q;
	logic [FIELD_W-1:0] max_bases_q;

	logic [AW-1:0]  clr_ptr_q;
	logic [AW-1:0]  inc_addr_q;
	logic           sweep_reply_q;
	logic           pend_kind_q;

	logic           out_valid_q;
	logic           resp_kind_q;
	logic [FIELD_W-1:0] bin_count_q;
	logic [FIELD_W-1:0] bases_seen_q;

	logic           accept;
	kfc_win_ctl_t   win_ctl;
	logic           count_en;
	logic [AW-1:0]  win_next;
	logic [FIELD_W-1:0] base_cnt;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [CW-1:0]  mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [CW-1:0]  mem_rdata;

	logic [AW+BIN_W-1:0]   bin_ext;
	logic [CW+FIELD_W-1:0] count_ext;
	logic           out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RESET;
			max_bases_q   <= MAX_BASES_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KMER_LENGTH: kmer_length_q <= cfg_data[KLEN_W-1:0];
				REG_MAX_BASES:   max_bases_q   <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign win_ctl.step  = accept && (req_type == REQ_SEQ);
	assign win_ctl.clear = accept && (req_type == REQ_CLEAR);

	kfc_window #(
		.MAX_KMER(MAX_KMER)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (win_ctl),
		.char_code  (char_code),
		.kmer_length(kmer_length_q),
		.max_bases  (max_bases_q),
		.count_en   (count_en),
		.win_next   (win_next),
		.bases_seen (base_cnt)
	);

	// bin index masked or zero-extended to the table's address width
	assign bin_ext   = {AW'(0), bin_index};
	assign count_ext = {FIELD_W'(0), mem_rdata};

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = win_next;
		if (accept && req_type == REQ_SEQ) begin
			mem_re = count_en;
		end else if (accept && req_type == REQ_READ) begin
			mem_re    = 1'b1;
			mem_raddr = bin_ext[AW-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_ptr_q;
		mem_wdata = '0;
		case (state_q)
			ST_SWEEP: mem_we = 1'b1;
			ST_INC: begin
				mem_we    = 1'b1;
				mem_waddr = inc_addr_q;
				mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + CW'(1);
			end
			default: ;
		endcase
	end

	kfc_hist_mem #(
		.AW(AW),
		.DW(CW)
	) u_hist (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			clr_ptr_q     <= '0;
			sweep_reply_q <= 1'b0;
			pend_kind_q   <= RESP_READ;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					clr_ptr_q <= clr_ptr_q + AW'(1);
					if (&clr_ptr_q) begin
						state_q <= sweep_reply_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_SEQ: begin
								if (count_en) begin
									state_q <= ST_INC;
								end
							end
							REQ_READ: begin
								pend_kind_q <= RESP_READ;
								state_q     <= ST_RESP;
							end
							REQ_CLEAR: begin
								pend_kind_q   <= RESP_CLEAR;
								sweep_reply_q <= 1'b1;
								state_q       <= ST_SWEEP;
							end
							default: ;
						endcase
					end
				end
				ST_INC: state_q <= ST_IDLE;
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_SEQ) begin
			inc_addr_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			resp_kind_q <= pend_kind_q;
			if (pend_kind_q == RESP_CLEAR) begin
				bin_count_q  <= '0;
				bases_seen_q <= '0;
			end else begin
				bin_count_q  <= count_ext[FIELD_W-1:0];
				bases_seen_q <= base_cnt;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign resp_kind  = resp_kind_q;
	assign bin_count  = bin_count_q;
	assign bases_seen = bases_seen_q;

endmodule
`default_nettype wire

@@ rtl/kfc_checker.sv @@
// Port-level checks of the k-mer frequency counter, bound to the top level.
`default_nettype none
module kfc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [kfc_pkg::REQ_W-1:0]   req_type,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        resp_kind,
	input wire logic [kfc_pkg::FIELD_W-1:0] bin_count,
	input wire logic [kfc_pkg::FIELD_W-1:0] bases_seen
);
	import kfc_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(resp_kind)
			&& $stable(bin_count) && $stable(bases_seen))
		else $error("result changed while stalled");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resp_kind == RESP_CLEAR |-> bin_count == '0 && bases_seen == '0)
		else $error("clear reply carries non-zero fields");

	// a read or clear item blocks the input until its reply is under way
	a_reply_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_READ || req_type == REQ_CLEAR)
			|=> !in_ready)
		else $error("item taken while a reply is pending");

	a_reply_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a pending reply");

endmodule

bind kmer_frequency_counter kfc_checker u_kfc_checker (.*);
`default_nettype wire

@@ dv/tb_kmer_frequency_counter.sv @@
// Self-checking testbench for the k-mer frequency counter.
`default_nettype none
module tb_kmer_frequency_counter;
	import kfc_pkg::*;

	localparam int HIST_BINS     = 1 << BIN_W;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 500;
	localparam int N_PHASES      = 9;
	localparam int PHASE_ITEMS   = 45;
	// request code the block ignores
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [CHAR_W-1:0] ch;
		logic [BIN_W-1:0]  bin;
	} kmer_req_t;

	typedef struct packed {
		logic               kind;
		logic [FIELD_W-1:0] count;
		logic [FIELD_W-1:0] seen;
	} kmer_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_KMER_LENGTH;
	logic [FIELD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = REQ_SEQ;
	logic [CHAR_W-1:0] char_code = '0;
	logic [BIN_W-1:0] bin_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic resp_kind;
	logic [FIELD_W-1:0] bin_count;
	logic [FIELD_W-1:0] bases_seen;

	kmer_req_t   req_backlog[$];
	kmer_reply_t replies_due[$];
	kmer_req_t   cur_req;

	// shadow of the block's state
	logic [FIELD_W-1:0] hist_model[HIST_BINS];
	logic [BIN_W-1:0]   win_model;
	logic [FIELD_W-1:0] bases_model;
	logic               hdr_model;
	logic [KLEN_W-1:0]  klen_model;
	logic [FIELD_W-1:0] maxb_model;

	int n_fail = 0;
	int n_accepted = 0;
	int n_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit calm = 1'b0;
	// generator's own guess of the current window, to aim reads at live bins
	logic [BIN_W-1:0] gen_win = '0;
	int gen_k = 1;

	kmer_frequency_counter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.char_code  (char_code),
		.bin_index  (bin_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.resp_kind  (resp_kind),
		.bin_count  (bin_count),
		.bases_seen (bases_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int base_value(logic [CHAR_W-1:0] ch);
		case (ch)
		CHAR_A_UC, CHAR_A_LC: return 0;
		CHAR_C_UC, CHAR_C_LC: return 1;
		CHAR_G_UC, CHAR_G_LC: return 2;
		CHAR_T_UC, CHAR_T_LC: return 3;
		default: return 4;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] base_char(int sel);
		case (sel)
		0: return CHAR_A_UC;
		1: return CHAR_C_UC;
		2: return CHAR_G_UC;
		3: return CHAR_T_UC;
		4: return CHAR_A_LC;
		5: return CHAR_C_LC;
		6: return CHAR_G_LC;
		default: return CHAR_T_LC;
		endcase
	endfunction

	function automatic int kmer_size(logic [KLEN_W-1:0] klen);
		return (klen == 0) ? 1 : int'(klen);
	endfunction

	function automatic void start_sequence();
		foreach (hist_model[i])
			hist_model[i] = '0;
		win_model = '0;
		bases_model = '0;
		hdr_model = 1'b1;
	endfunction

	// advance the shadow state by one accepted request
	function automatic void track_request(kmer_req_t r);
		int code;
		int kk;
		int msk;
		kmer_reply_t rep;
		case (r.req)
		REQ_SEQ: begin
			if (hdr_model) begin
				if (r.ch == CHAR_NEWLINE)
					hdr_model = 1'b0;
				return;
			end
			code = base_value(r.ch);
			if (code > 3 || bases_model >= maxb_model)
				return;
			kk = kmer_size(klen_model);
			msk = (1 << (2 * kk)) - 1;
			win_model = BIN_W'((int'(win_model) >> 2 | code << (2 * kk - 2)) & msk);
			bases_model = bases_model + 1'b1;
			if (bases_model >= kk && hist_model[win_model] != '1)
				hist_model[win_model] = hist_model[win_model] + 1'b1;
		end
		REQ_READ: begin
			rep.kind = RESP_READ;
			rep.count = hist_model[r.bin];
			rep.seen = bases_model;
			replies_due.insert(replies_due.size(), rep);
		end
		REQ_CLEAR: begin
			start_sequence();
			rep.kind = RESP_CLEAR;
			rep.count = '0;
			rep.seen = '0;
			replies_due.insert(replies_due.size(), rep);
		end
		default: ;
		endcase
	endfunction

	function automatic void queue_req(logic [REQ_W-1:0] rq, logic [CHAR_W-1:0] ch,
			logic [BIN_W-1:0] bin);
		kmer_req_t r;
		r.req = rq;
		r.ch = ch;
		r.bin = bin;
		req_backlog.insert(req_backlog.size(), r);
	endfunction

	function automatic void queue_base(int sel);
		int msk;
		msk = (1 << (2 * gen_k)) - 1;
		gen_win = BIN_W'((int'(gen_win) >> 2 | (sel % 4) << (2 * gen_k - 2)) & msk);
		queue_req(REQ_SEQ, base_char(sel), BIN_W'($urandom));
	endfunction

	// one FASTA stretch: optional clear and header, then bases, noise and reads
	function automatic void queue_stretch(int n_items, bit fresh);
		int roll;
		int pick;
		logic [BIN_W-1:0] bin;
		if (fresh) begin
			queue_req(REQ_CLEAR, CHAR_W'($urandom), BIN_W'($urandom));
			gen_win = '0;
			repeat ($urandom_range(0, 8)) begin
				do pick = $urandom_range(0, 255); while (pick == CHAR_NEWLINE);
				queue_req(REQ_SEQ, CHAR_W'(pick), BIN_W'($urandom));
			end
			queue_req(REQ_SEQ, CHAR_NEWLINE, BIN_W'($urandom));
		end
		repeat (n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				queue_base($urandom_range(0, 7));
			end else if (roll < 78) begin
				queue_req(REQ_SEQ, CHAR_W'($urandom), BIN_W'($urandom));
			end else if (roll < 98) begin
				pick = $urandom_range(0, 3);
				if (pick < 2)
					bin = gen_win;
				else if (pick == 2)
					bin = BIN_W'($urandom_range(0, (1 << (2 * gen_k)) - 1));
				else
					bin = BIN_W'($urandom);
				queue_req(REQ_READ, CHAR_W'($urandom), bin);
			end else begin
				queue_req(REQ_NONE, CHAR_W'($urandom), BIN_W'($urandom));
			end
		end
	endfunction

	task automatic write_reg(logic idx, logic [FIELD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_KMER_LENGTH) begin
			klen_model = val[KLEN_W-1:0];
			gen_k = kmer_size(klen_model);
		end else begin
			maxb_model = val;
		end
	endtask

	// block idle: nothing queued, nothing offered, nothing owed
	task automatic wait_quiet();
		while (req_backlog.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_req
		logic nxt_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				track_request(cur_req);
				n_accepted++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(1, 14) - 1;
				end else if (req_backlog.size() > 0) begin
					cur_req = req_backlog.pop_front();
					req_type <= cur_req.req;
					char_code <= cur_req.ch;
					bin_index <= cur_req.bin;
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive_ready
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rdy = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && n_accepted >= HOLD_AT) begin
				// long back-pressure so the block fills and blocks its input
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				rdy = 1'b0;
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin : check_reply
		kmer_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result: resp_kind %0d bin_count %0d bases_seen %0d",
					resp_kind, bin_count, bases_seen);
				n_fail++;
			end else begin
				want = replies_due.pop_front();
				if (resp_kind !== want.kind) begin
					$error("resp_kind: expected %0d, got %0d", want.kind, resp_kind);
					n_fail++;
				end
				if (bin_count !== want.count) begin
					$error("bin_count: expected %0d, got %0d", want.count, bin_count);
					n_fail++;
				end
				if (bases_seen !== want.seen) begin
					$error("bases_seen: expected %0d, got %0d", want.seen, bases_seen);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		logic [FIELD_W-1:0] word;
		logic [FIELD_W-1:0] mb;
		int kk;
		bit fresh;
		start_sequence();
		klen_model = KMER_LENGTH_RESET;
		maxb_model = MAX_BASES_RESET;
		gen_k = kmer_size(klen_model);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: k = 2 with junk in the upper data bits, no base limit
		write_reg(REG_KMER_LENGTH, 24'hFFFFFA);
		write_reg(REG_MAX_BASES, '1);
		queue_req(REQ_SEQ, CHAR_A_UC, '1);
		queue_req(REQ_SEQ, CHAR_W'(8'h3E), '0);
		queue_req(REQ_SEQ, CHAR_NEWLINE, '0);
		for (int i = 0; i < 8; i++)
			queue_req(REQ_SEQ, base_char(i), '0);
		queue_req(REQ_SEQ, '0, '0);
		queue_req(REQ_SEQ, '1, '1);
		queue_req(REQ_NONE, '1, '1);
		queue_req(REQ_READ, '0, '0);
		queue_req(REQ_READ, '1, '1);
		queue_req(REQ_READ, '0, BIN_W'(4));
		queue_req(REQ_READ, '0, BIN_W'(9));
		queue_req(REQ_READ, '0, BIN_W'(14));
		queue_req(REQ_CLEAR, '1, '1);
		queue_req(REQ_READ, '0, BIN_W'(4));
		wait_quiet();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 1)
				calm = 1'b1;
			case (p)
			0: begin kk = 7; mb = '1; fresh = 1'b1; end
			1: begin kk = 1; mb = '0; fresh = 1'b0; end
			2: begin kk = 0; mb = 24'd1; fresh = 1'b1; end
			default: begin
				kk = $urandom_range(0, 7);
				case ($urandom_range(0, 4))
				0: mb = FIELD_W'($urandom_range(2, 80));
				1: mb = '1;
				2: mb = 24'd1;
				default: mb = FIELD_W'($urandom_range(1, 16777215));
				endcase
				fresh = 1'($urandom_range(0, 1));
			end
			endcase
			word = FIELD_W'($urandom);
			word[KLEN_W-1:0] = KLEN_W'(kk);
			write_reg(REG_KMER_LENGTH, word);
			write_reg(REG_MAX_BASES, mb);
			queue_stretch(PHASE_ITEMS, fresh);
			wait_quiet();
		end

		if (replies_due.size() != 0) begin
			$error("%0d results never arrived", replies_due.size());
			n_fail++;
		end
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/kfc_pkg.sv
rtl/kfc_hist_mem.sv
rtl/kfc_window.sv
rtl/kmer_frequency_counter.sv
rtl/kfc_checker.sv
dv/tb_kmer_frequency_counter.sv
